FILE: sv/gba_pkg.sv
// ============================================================================
// gba_pkg: shared types and constants of the grid bin averager
// Mode codes, saturation limits and state encodings.
// ============================================================================
package gba_pkg;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_X_ORIGIN  = 3'd0,
        REG_Y_ORIGIN  = 3'd1,
        REG_X_SCALE   = 3'd2,
        REG_Y_SCALE   = 3'd3,
        REG_GRID_COLS = 3'd4,
        REG_GRID_ROWS = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_UPDATE,
        ST_DIVIDE,
        ST_ROUND,
        ST_OUT
    } state_t;

    localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;
    localparam int                 DIV_W   = 48;

    // result of one axis lookup
    typedef struct packed {
        logic        hit;
        logic [32:0] idx;
    } axis_t;

endpackage

FILE: sv/gba_axis.sv
// ============================================================================
// gba_axis: one axis of the cell lookup
// Registered multiply of the coordinate offset by the scale, then rounding
// half away from zero and a range check against the grid size in use.
// ============================================================================
module gba_axis
    import gba_pkg::*;
(
    input  logic               clk,
    input  logic               load,
    input  logic signed [31:0] coord,
    input  logic signed [31:0] origin,
    input  logic        [31:0] scale,
    input  logic        [12:0] limit,
    output axis_t              result
);

    logic signed [32:0] diff;
    logic        [32:0] mag;
    logic               neg_reg;
    logic        [64:0] prod_reg;
    logic        [32:0] rounded;

    assign diff = 33'(coord) - 33'(origin);
    assign mag  = diff[32] ? 33'(-diff) : diff;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg  <= diff[32];
            prod_reg <= 65'(mag) * 65'(scale);
        end
    end

    assign rounded    = prod_reg[64:32] + 33'(prod_reg[31]);
    assign result.idx = rounded;
    assign result.hit = !(neg_reg && rounded != '0) && (rounded < 33'(limit));

endmodule

FILE: sv/gba_divider.sv
// ============================================================================
// gba_divider: restoring divider
// Unsigned 48 by 16 bit division, one quotient bit per cycle.
// ============================================================================
module gba_divider
    import gba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [15:0]       divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic [DIV_W-1:0] quot_reg, quot_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      dsr_reg;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [16:0]      trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quot_reg[DIV_W-1]};
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = 6'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next  = 16'(trial - {1'b0, dsr_reg});
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[15:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
            dsr_reg <= divisor;
    end

    assign done     = busy_reg && cnt_reg == 6'd1;
    assign quotient = quot_next;

endmodule

FILE: sv/grid_bin_averager.sv
// ============================================================================
// grid_bin_averager: scattered sample binning into a 2-D grid
// Accumulates Q16.16 samples per cell and answers cell averages.
// ============================================================================
// Cell sums and counts live in one synchronous memory with one entry per cell
// (each grid size rounded up to a power of two), each with an epoch mark.
// After reset and on every clear request the block sweeps the whole memory
// once, one entry a cycle, and accepts no request meanwhile; configuration
// writes are taken at all times. An add request passes through a registered
// multiply for the cell index, the memory read and the write-back. A query
// request for a cell that is empty or outside the grid skips the division;
// otherwise it runs the 48-bit restoring divider, which produces one quotient
// bit per cycle. One request is in flight at a time; a result waits in the
// output register while the next request is taken.
module grid_bin_averager
    import gba_pkg::*;
#(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    input  logic signed [31:0] sample_value,
    input  logic               sample_flagged,
    input  logic [7:0]         query_row,
    input  logic [7:0]         query_col,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] cell_average,
    output logic               cell_empty,
    output logic [15:0]        cell_count,
    output logic               sample_accepted,
    output logic [31:0]        inserted_total
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int CELLS = 1 << ADDR_W;

    // ---------------- configuration ----------------
    logic signed [31:0] x_origin_reg, y_origin_reg;
    logic [31:0]        x_scale_reg, y_scale_reg;
    logic [8:0]         grid_cols_reg, grid_rows_reg;
    logic [12:0]        cols_used, rows_used;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg  <= '0;
            y_origin_reg  <= '0;
            x_scale_reg   <= 32'd65536;
            y_scale_reg   <= 32'd65536;
            grid_cols_reg <= 9'd256;
            grid_rows_reg <= 9'd256;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_X_ORIGIN:  x_origin_reg  <= cfg_data;
                REG_Y_ORIGIN:  y_origin_reg  <= cfg_data;
                REG_X_SCALE:   x_scale_reg   <= cfg_data;
                REG_Y_SCALE:   y_scale_reg   <= cfg_data;
                REG_GRID_COLS: grid_cols_reg <= cfg_data[8:0];
                REG_GRID_ROWS: grid_rows_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign cols_used = (13'(grid_cols_reg) > 13'(MAX_COLS)) ? 13'(MAX_COLS)
                                                            : 13'(grid_cols_reg);
    assign rows_used = (13'(grid_rows_reg) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS)
                                                            : 13'(grid_rows_reg);

    // ---------------- request capture ----------------
    state_t             state_reg, state_next;
    mode_t              mode_reg;
    logic signed [31:0] value_reg;
    logic               flag_reg;
    logic [7:0]         qrow_reg, qcol_reg;
    logic               take;
    axis_t              x_res, y_res;

    assign take = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mode_reg  <= mode_t'(mode);
            value_reg <= sample_value;
            flag_reg  <= sample_flagged;
            qrow_reg  <= query_row;
            qcol_reg  <= query_col;
        end
    end

    gba_axis u_x_axis (
        .clk    (clk),
        .load   (take),
        .coord  (x_coord),
        .origin (x_origin_reg),
        .scale  (x_scale_reg),
        .limit  (cols_used),
        .result (x_res)
    );

    gba_axis u_y_axis (
        .clk    (clk),
        .load   (take),
        .coord  (y_coord),
        .origin (y_origin_reg),
        .scale  (y_scale_reg),
        .limit  (rows_used),
        .result (y_res)
    );

    // ---------------- cell memory ----------------
    logic [64:0]       cell_mem [CELLS];
    logic [64:0]       rd_data_reg;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              epoch_reg, epoch_next;
    logic              hit_reg, hit_next;
    logic              wr_en;
    logic [64:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            cell_mem[wr_en && state_reg == ST_CLEAR ? sweep_reg : addr_reg] <= wr_data;
        if (rd_en)
            rd_data_reg <= cell_mem[addr_next];
    end

    logic              cell_live;
    logic signed [47:0] cur_sum;
    logic [15:0]       cur_cnt;
    logic signed [48:0] new_sum_wide;
    logic signed [47:0] new_sum;

    assign cell_live    = rd_data_reg[64] == epoch_reg;
    assign cur_sum      = cell_live ? $signed(rd_data_reg[63:16]) : '0;
    assign cur_cnt      = cell_live ? rd_data_reg[15:0] : '0;
    assign new_sum_wide = 49'(cur_sum) + 49'(value_reg);
    assign new_sum      = (new_sum_wide > 49'(SUM_MAX)) ? SUM_MAX :
                          (new_sum_wide < 49'(SUM_MIN)) ? SUM_MIN :
                          new_sum_wide[47:0];

    // ---------------- divider ----------------
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_quot;
    logic [DIV_W-1:0]  div_dividend;
    logic              sneg_reg;
    logic [15:0]       cnt_hold_reg;
    logic [DIV_W-1:0]  quot_reg;

    assign div_dividend = (cur_sum[47] ? DIV_W'(-cur_sum) : DIV_W'(cur_sum))
                          + DIV_W'(cur_cnt >> 1);

    gba_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cur_cnt),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ---------------- totals and output register ----------------
    logic [31:0]        total_reg, total_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] avg_reg, avg_next;
    logic               empty_reg, empty_next;
    logic [15:0]        count_reg, count_next;
    logic               acc_reg, acc_next;
    logic [31:0]        tot_out_reg, tot_out_next;
    logic               out_free;
    logic signed [48:0] avg_wide;

    assign out_free = !out_valid_reg || out_ready;
    assign avg_wide = sneg_reg ? -49'(quot_reg) : 49'(quot_reg);

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        epoch_next     = epoch_reg;
        hit_next       = hit_reg;
        sweep_next     = sweep_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        avg_next       = avg_reg;
        empty_next     = empty_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        tot_out_next   = tot_out_reg;
        in_ready       = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_data        = {epoch_reg, new_sum, (cur_cnt == 16'hFFFF) ? cur_cnt
                                                                    : cur_cnt + 16'd1};
        div_start      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en      = 1'b1;
                wr_data    = {epoch_reg, 64'd0};
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == ADDR_W'(CELLS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (mode_t'(mode))
                        MODE_CLEAR:
                        begin
                            epoch_next = !epoch_reg;
                            total_next = '0;
                            state_next = ST_OUT;
                        end
                        default: state_next = ST_READ;
                    endcase
                end
            end
            ST_READ:
            begin
                rd_en = 1'b1;
                if (mode_reg == MODE_ADD)
                begin
                    hit_next  = !flag_reg && x_res.hit && y_res.hit;
                    addr_next = {y_res.idx[ROW_W-1:0], x_res.idx[COL_W-1:0]};
                end
                else
                begin
                    hit_next  = (13'(qrow_reg) < rows_used) && (13'(qcol_reg) < cols_used);
                    addr_next = {ROW_W'(qrow_reg), COL_W'(qcol_reg)};
                end
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (mode_reg == MODE_ADD)
                begin
                    if (hit_reg)
                    begin
                        wr_en = 1'b1;
                        if (total_reg != 32'hFFFF_FFFF)
                            total_next = total_reg + 32'd1;
                    end
                    state_next = ST_OUT;
                end
                else if (mode_reg == MODE_QUERY && hit_reg && cur_cnt != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
                else
                    state_next = ST_OUT;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    avg_next       = '0;
                    empty_next     = 1'b0;
                    count_next     = '0;
                    acc_next       = 1'b0;
                    tot_out_next   = total_reg;
                    if (mode_reg == MODE_ADD)
                        acc_next = hit_reg;
                    else if (mode_reg == MODE_QUERY)
                    begin
                        empty_next = !(hit_reg && cur_cnt != '0);
                        if (hit_reg)
                            count_next = cur_cnt;
                        if (hit_reg && cur_cnt != '0)
                            avg_next = (avg_wide > 49'sd2147483647) ? 32'sh7FFF_FFFF :
                                       (avg_wide < -49'sd2147483648) ? 32'sh8000_0000 :
                                       avg_wide[31:0];
                    end
                    if (mode_reg == MODE_CLEAR)
                        state_next = ST_CLEAR;
                    else
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            epoch_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            epoch_reg     <= epoch_next;
            hit_reg       <= hit_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        avg_reg     <= avg_next;
        empty_reg   <= empty_next;
        count_reg   <= count_next;
        acc_reg     <= acc_next;
        tot_out_reg <= tot_out_next;
        if (div_start)
        begin
            sneg_reg     <= cur_sum[47];
            cnt_hold_reg <= cur_cnt;
        end
        if (div_done)
            quot_reg <= div_quot;
    end

    assign out_valid       = out_valid_reg;
    assign cell_average    = avg_reg;
    assign cell_empty      = empty_reg;
    assign cell_count      = count_reg;
    assign sample_accepted = acc_reg;
    assign inserted_total  = tot_out_reg;

    // ---------------- assertions ----------------
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("request taken outside idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && state_reg != ST_CLEAR |-> mode_reg == MODE_ADD && hit_reg)
        else $error("cell write without accepted sample");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> cnt_hold_reg != '0)
        else $error("divide by zero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cell_empty |-> cell_average == '0)
        else $error("empty cell with nonzero average");

endmodule

FILE: dv/tb_grid_bin_averager.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_grid_bin_averager: self-checking bench of the grid bin averager
// Drives add, query, clear and unused requests under several grid settings,
// predicts each result with its own copy of the cell stores and compares it
// field by field, with random idling on both sides of the handshake.
// ============================================================================
module tb_grid_bin_averager;
    import gba_pkg::*;

    localparam int          GRID_W      = 256;
    localparam int          GRID_H      = 256;
    localparam longint      CYCLE_LIMIT = 16000000;
    localparam int          DRAIN_WAIT  = 80;

    typedef struct {
        mode_t              mode;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] value;
        logic               flagged;
        logic [7:0]         row;
        logic [7:0]         col;
    } sample_req_t;

    typedef struct {
        logic signed [31:0] average;
        logic               empty;
        logic [15:0]        count;
        logic               accepted;
        logic [31:0]        total;
    } cell_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         mode;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] sample_value;
    logic               sample_flagged;
    logic [7:0]         query_row;
    logic [7:0]         query_col;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] cell_average;
    logic               cell_empty;
    logic [15:0]        cell_count;
    logic               sample_accepted;
    logic [31:0]        inserted_total;

    // predictor state
    logic signed [31:0] x_org, y_org;
    logic [31:0]        x_scl, y_scl;
    logic [8:0]         n_cols, n_rows;
    longint             sum_store[int unsigned];
    int unsigned        count_store[int unsigned];
    logic [31:0]        running_total;

    cell_result_t       pending_results[$];
    int                 error_count;
    longint             cycle_count;
    bit                 idling_on;
    int                 ready_stall;

    grid_bin_averager dut (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_grid_bin_averager NOT OK");
            $finish;
        end
    end

    function automatic bit axis_lookup(logic signed [31:0] coord, logic signed [31:0] org,
                                       logic [31:0] scl, int unsigned lim,
                                       output int unsigned idx);
        longint      d;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] r;
        d    = longint'(coord) - longint'(org);
        mag  = (d < 0) ? 64'(-d) : 64'(d);
        prod = mag * {32'd0, scl};
        r    = (prod >> 32) + {63'd0, prod[31]};
        idx  = 0;
        if (d < 0 && r != 0)
            return 0;
        if (r >= lim)
            return 0;
        idx = int'(r);
        return 1;
    endfunction

    function automatic logic signed [31:0] rounded_mean(longint s, int unsigned c);
        logic [63:0] mag;
        logic [63:0] q;
        longint      v;
        mag = (s < 0) ? 64'(-s) : 64'(s);
        q   = (mag + c / 2) / c;
        v   = (s < 0) ? -longint'(q) : longint'(q);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic void predict_request(sample_req_t r);
        cell_result_t res;
        int unsigned  cols, rows, ci, ri, a, cnt;
        longint       s;
        cols = (n_cols > GRID_W) ? GRID_W : n_cols;
        rows = (n_rows > GRID_H) ? GRID_H : n_rows;
        res  = '{average: 0, empty: 0, count: 0, accepted: 0, total: 0};
        case (r.mode)
            MODE_ADD:
            begin
                if (!r.flagged && axis_lookup(r.x, x_org, x_scl, cols, ci)
                        && axis_lookup(r.y, y_org, y_scl, rows, ri))
                begin
                    a = ri * GRID_W + ci;
                    s = (sum_store.exists(a) ? sum_store[a] : 0) + longint'(r.value);
                    if (s > longint'(SUM_MAX))
                        s = SUM_MAX;
                    if (s < longint'(SUM_MIN))
                        s = SUM_MIN;
                    sum_store[a] = s;
                    cnt = count_store.exists(a) ? count_store[a] : 0;
                    if (cnt != 65535)
                        count_store[a] = cnt + 1;
                    if (running_total != 32'hFFFF_FFFF)
                        running_total++;
                    res.accepted = 1;
                end
            end
            MODE_QUERY:
            begin
                res.empty = 1;
                if (r.row < rows && r.col < cols)
                begin
                    a   = r.row * GRID_W + r.col;
                    cnt = count_store.exists(a) ? count_store[a] : 0;
                    res.count = cnt[15:0];
                    if (cnt != 0)
                    begin
                        res.empty   = 0;
                        res.average = rounded_mean(sum_store[a], cnt);
                    end
                end
            end
            MODE_CLEAR:
            begin
                sum_store.delete();
                count_store.delete();
                running_total = 0;
            end
            default:
            begin
            end
        endcase
        res.total = running_total;
        pending_results.push_back(res);
    endfunction

    always @(posedge clk)
    begin
        cell_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, average %0d", $realtime,
                         cell_average);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (cell_average !== e.average)
                begin
                    $display("%0t: cell_average exp %0d got %0d", $realtime, e.average,
                             cell_average);
                    error_count++;
                end
                if (cell_empty !== e.empty)
                begin
                    $display("%0t: cell_empty exp %0d got %0d", $realtime, e.empty, cell_empty);
                    error_count++;
                end
                if (cell_count !== e.count)
                begin
                    $display("%0t: cell_count exp %0d got %0d", $realtime, e.count, cell_count);
                    error_count++;
                end
                if (sample_accepted !== e.accepted)
                begin
                    $display("%0t: sample_accepted exp %0d got %0d", $realtime, e.accepted,
                             sample_accepted);
                    error_count++;
                end
                if (inserted_total !== e.total)
                begin
                    $display("%0t: inserted_total exp %0d got %0d", $realtime, e.total,
                             inserted_total);
                    error_count++;
                end
            end
        end
    end

    // hold off the result side in bursts
    always @(negedge clk)
    begin
        if (ready_stall > 0)
        begin
            ready_stall <= ready_stall - 1;
            out_ready   <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 9) == 0)
        begin
            ready_stall <= $urandom_range(0, 16);
            out_ready   <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_request(sample_req_t r);
        int gap;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= r.mode;
        x_coord        <= r.x;
        y_coord        <= r.y;
        sample_value   <= r.value;
        sample_flagged <= r.flagged;
        query_row      <= r.row;
        query_col      <= r.col;
        do
            @(posedge clk);
        while (!in_ready);
        predict_request(r);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_register(reg_index_t idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_X_ORIGIN:  x_org  = data;
            REG_Y_ORIGIN:  y_org  = data;
            REG_X_SCALE:   x_scl  = data;
            REG_Y_SCALE:   y_scl  = data;
            REG_GRID_COLS: n_cols = data[8:0];
            REG_GRID_ROWS: n_rows = data[8:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(logic [31:0] xo, logic [31:0] yo, logic [31:0] xs,
                            logic [31:0] ys, logic [8:0] cols, logic [8:0] rows);
        drain_results();
        write_register(REG_X_ORIGIN, xo);
        write_register(REG_Y_ORIGIN, yo);
        write_register(REG_X_SCALE, xs);
        write_register(REG_Y_SCALE, ys);
        write_register(REG_GRID_COLS, {23'd0, cols});
        write_register(REG_GRID_ROWS, {23'd0, rows});
    endtask

    function automatic sample_req_t make_request(mode_t m, logic signed [31:0] x,
                                                 logic signed [31:0] y,
                                                 logic signed [31:0] v, logic f,
                                                 logic [7:0] row, logic [7:0] col);
        sample_req_t r;
        r = '{mode: m, x: x, y: y, value: v, flagged: f, row: row, col: col};
        return r;
    endfunction

    // coordinate near the center of cell n along one axis, jittered
    function automatic logic signed [31:0] coord_near(logic signed [31:0] org,
                                                      logic [31:0] scl, int n);
        longint pitch;
        longint jit;
        pitch = (scl == 0) ? 64'sd65536 : longint'((64'd1 << 32) / scl);
        if (pitch > 64'sd100000000)
            pitch = 64'sd100000000;
        jit = longint'($urandom_range(0, 32'(pitch))) - pitch / 2;
        return 32'(longint'(org) + n * pitch + jit);
    endfunction

    function automatic sample_req_t random_request();
        sample_req_t r;
        int          pick, cols, rows;
        cols = (n_cols > GRID_W) ? GRID_W : n_cols;
        rows = (n_rows > GRID_H) ? GRID_H : n_rows;
        r = make_request(MODE_ADD, $urandom, $urandom, $urandom, 1'b0, 8'($urandom),
                         8'($urandom));
        pick = $urandom_range(0, 999);
        if (pick < 3)
            r.mode = MODE_CLEAR;
        else if (pick < 60)
        begin
            r.mode    = mode_t'($urandom_range(0, 3));
            r.flagged = 1'($urandom);
        end
        else if (pick < 330)
        begin
            r.mode = MODE_QUERY;
            r.row  = 8'($urandom_range(0, (rows > 254) ? 255 : rows + 1));
            r.col  = 8'($urandom_range(0, (cols > 254) ? 255 : cols + 1));
        end
        else
        begin
            r.x       = coord_near(x_org, x_scl, $urandom_range(0, cols + 1) - 1);
            r.y       = coord_near(y_org, y_scl, $urandom_range(0, rows + 1) - 1);
            r.flagged = ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 3) == 0)
                r.value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end
        return r;
    endfunction

    task automatic run_random(int n);
        repeat (n) send_request(random_request());
    endtask

    task automatic test_directed();
        send_request(make_request(MODE_QUERY, 0, 0, 0, 0, 8'd0, 8'd0));
        send_request(make_request(MODE_ADD, 32'sh0000_8000, 0, 32'sh7FFF_FFFF, 0, 0, 0));
        send_request(make_request(MODE_ADD, 32'sh0000_8000, 0, 32'sh7FFF_FFFF, 0, 0, 0));
        send_request(make_request(MODE_QUERY, 0, 0, 0, 0, 8'd0, 8'd1));
        send_request(make_request(MODE_ADD, -32'sh0000_8000, 0, 5, 0, 0, 0));
        send_request(make_request(MODE_ADD, -32'sh0000_6666, 0, -32'sd1, 0, 0, 0));
        send_request(make_request(MODE_ADD, 32'sh0000_6666, 0, -32'sd2, 0, 0, 0));
        send_request(make_request(MODE_QUERY, 0, 0, 0, 0, 8'd0, 8'd0));
        send_request(make_request(MODE_ADD, 32'sh00FF_0000, 32'sh00FF_0000,
                                  32'sh8000_0000, 0, 0, 0));
        send_request(make_request(MODE_ADD, 32'sh00FF_0000, 32'sh00FF_0000,
                                  32'sh8000_0000, 1, 0, 0));
        send_request(make_request(MODE_QUERY, 0, 0, 0, 0, 8'hFF, 8'hFF));
        send_request(make_request(MODE_ADD, 32'sh7FFF_FFFF, 0, 1, 0, 0, 0));
        send_request(make_request(MODE_ADD, 0, 32'sh8000_0000, 1, 0, 0, 0));
        send_request(make_request(MODE_ADD, 32'sh0100_0000, 0, 1, 0, 0, 0));
        send_request(make_request(MODE_NONE, 32'sh0000_8000, 0, 7, 0, 8'd0, 8'd0));
        send_request(make_request(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
        send_request(make_request(MODE_QUERY, 0, 0, 0, 0, 8'd0, 8'd1));
    endtask

    task automatic test_grid_settings();
        set_grid(0, 0, 32'd65536, 32'd65536, 9'd12, 9'd9);
        run_random(200);
        send_request(make_request(MODE_QUERY, 0, 0, 0, 0, 8'd9, 8'd11));
        set_grid(-32'sh0003_8000, 32'sh0002_0000, 32'd32768, 32'd131072, 9'd1, 9'd1);
        run_random(120);
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 9'd0, 9'd300);
        run_random(60);
        set_grid(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 9'd511, 9'd256);
        run_random(60);
        set_grid($urandom, $urandom, $urandom_range(20000, 400000),
                 $urandom_range(20000, 400000), 9'd6, 9'd5);
        run_random(200);
    endtask

    task automatic test_pause_until_empty();
        set_grid(32'hFFFF_0000, 0, 32'd65536, 32'd98304, 9'd8, 9'd8);
        run_random(150);
        drain_results();
        run_random(150);
    endtask

    task automatic test_back_to_back();
        set_grid(0, 0, 32'd65536, 32'd65536, 9'd4, 9'd4);
        run_random(60);
        drain_results();
        idling_on = 0;
        run_random(200);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_X_ORIGIN;
        cfg_data       = '0;
        in_valid       = 1'b0;
        mode           = MODE_ADD;
        x_coord        = '0;
        y_coord        = '0;
        sample_value   = '0;
        sample_flagged = 1'b0;
        query_row      = '0;
        query_col      = '0;
        out_ready      = 1'b0;
        ready_stall    = 0;
        error_count    = 0;
        cycle_count    = 0;
        idling_on      = 1;
        x_org          = 0;
        y_org          = 0;
        x_scl          = 32'd65536;
        y_scl          = 32'd65536;
        n_cols         = 9'd256;
        n_rows         = 9'd256;
        running_total  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_grid_settings();
        test_pause_until_empty();
        test_back_to_back();

        drain_results();
        if (error_count == 0)
            $display("tb_grid_bin_averager OK");
        else
            $display("tb_grid_bin_averager NOT OK");
        $finish;
    end

endmodule
